/* hw/rtl/ciu_pkg.sv */
// Shared constants, types and a helper function for the icon pixel unpacker.
`default_nettype none

package ciu_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam logic [8:0] TABLE_LIMIT = 9'(TABLE_DEPTH);

  localparam int PADDR_W = 4;

  localparam logic [1:0] KIND_TABLE = 2'd0;
  localparam logic [1:0] KIND_BODY  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  typedef struct packed {
    logic [7:0] icon_width;
    logic [7:0] icon_height;
    logic [3:0] bits_per_point;
  } cfg_t;

  typedef struct packed {
    logic table_write;
    logic start_icon;
    logic mark_finished;
    logic load_byte;
    logic lookup;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic icon_empty;
    logic more;
  } dp_stat_t;

  // A setting of zero acts as one bit, anything above eight as eight.
  function automatic logic [3:0] effective_bpp(input logic [3:0] bpp);
    logic [3:0] r;
    if (bpp == 4'd0) begin
      r = 4'd1;
    end else if (bpp > 4'd8) begin
      r = 4'd8;
    end else begin
      r = bpp;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ciu_if.sv */
// Valid/ready channel interfaces for input items and output pixels.
`default_nettype none

interface ciu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] table_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [7:0] body_byte;

  modport source (
    output valid, kind, table_index, red_level, green_level, blue_level, body_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, table_index, red_level, green_level, blue_level, body_byte,
    output ready
  );
endinterface

interface ciu_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  logic [7:0]  column;
  logic [7:0]  line;
  logic        last_of_byte;
  logic        icon_done;

  modport source (
    output valid, pixel_rgb, column, line, last_of_byte, icon_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_rgb, column, line, last_of_byte, icon_done,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/ciu_regs.sv */
// APB configuration registers: icon width, icon height and bits per point.
`default_nettype none

module ciu_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ciu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output ciu_pkg::cfg_t                    cfg
);
  import ciu_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.icon_width     <= 8'd0;
      cfg.icon_height    <= 8'd0;
      cfg.bits_per_point <= 4'd8;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  cfg.icon_width     <= pwdata[7:0];
        REG_HEIGHT: cfg.icon_height    <= pwdata[7:0];
        REG_BPP:    cfg.bits_per_point <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = {24'd0, cfg.icon_width};
      REG_HEIGHT: prdata = {24'd0, cfg.icon_height};
      REG_BPP:    prdata = {28'd0, cfg.bits_per_point};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ciu_ctrl.sv */
// Controller state machine that sequences item handling and pixel output.
`default_nettype none

module ciu_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire ciu_pkg::dp_stat_t stat,
  output ciu_pkg::dp_cmd_t  cmd
);
  import ciu_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_SHOW   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_beat;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SHOW);
  assign in_beat   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          case (in_kind)
            KIND_TABLE: cmd.table_write = 1'b1;
            KIND_START: cmd.start_icon  = 1'b1;
            KIND_BODY: begin
              if (!stat.finished) begin
                if (stat.icon_empty) begin
                  cmd.mark_finished = 1'b1;
                end else begin
                  cmd.load_byte = 1'b1;
                  state_next    = S_LOOKUP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          state_next = stat.more ? S_LOOKUP : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_show_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && !out_ready) |=> (state == S_SHOW))
    else $error("pixel beat withdrawn before it was taken");

  a_lookup_then_show: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> out_valid)
    else $error("table lookup not followed by a pixel beat");

  a_load_then_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |=> cmd.lookup)
    else $error("body byte loaded without decoding a pixel");

endmodule

`default_nettype wire

/* hw/rtl/ciu_datapath.sv */
// Datapath: colour table memory, bit buffer, raster position and pixel registers.
`default_nettype none

module ciu_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ciu_pkg::cfg_t    cfg,
  input  wire ciu_pkg::dp_cmd_t cmd,
  output ciu_pkg::dp_stat_t stat,
  input  wire logic [7:0]   table_index,
  input  wire logic [7:0]   red_level,
  input  wire logic [7:0]   green_level,
  input  wire logic [7:0]   blue_level,
  input  wire logic [7:0]   body_byte,
  output logic      [23:0]  pixel_rgb,
  output logic      [7:0]   column,
  output logic      [7:0]   line,
  output logic              last_of_byte,
  output logic              icon_done
);
  import ciu_pkg::*;

  logic [23:0]            colour_table [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic [14:0] bit_buffer;
  logic [3:0]  bits_held;
  logic [7:0]  x_position;
  logic [7:0]  y_position;
  logic        finished;
  logic [2:0]  pixel_count;
  logic        more;

  logic [23:0] rd_data;
  logic        rd_valid;
  logic        rd_in_range;

  logic [3:0]  bpp;
  logic [3:0]  shift;
  logic [7:0]  point_ref;
  logic        ref_in_range;
  logic        wr_in_range;
  logic [14:0] buffer_after;
  logic [8:0]  x_inc;
  logic [8:0]  y_inc;
  logic        row_wrap;
  logic        icon_end;
  logic        more_next;

  always_comb begin
    bpp          = effective_bpp(cfg.bits_per_point);
    shift        = bits_held - bpp;
    point_ref    = bit_buffer[7:0] & 8'd0;
    point_ref    = 8'(bit_buffer >> shift) & (8'hFF >> (4'd8 - bpp));
    ref_in_range = {1'b0, point_ref} < TABLE_LIMIT;
    wr_in_range  = {1'b0, table_index} < TABLE_LIMIT;
    buffer_after = bit_buffer & (15'h7FFF >> (4'd15 - shift));
    x_inc        = {1'b0, x_position} + 9'd1;
    y_inc        = {1'b0, y_position} + 9'd1;
    row_wrap     = x_inc >= {1'b0, cfg.icon_width};
    icon_end     = row_wrap && (y_inc >= {1'b0, cfg.icon_height});
    more_next    = (pixel_count != 3'd7) && (shift >= bpp) && !icon_end;
  end

  assign stat.finished   = finished;
  assign stat.icon_empty = (cfg.icon_width == 8'd0) || (cfg.icon_height == 8'd0) ||
                           (y_position >= cfg.icon_height);
  assign stat.more       = more;

  assign pixel_rgb = (rd_valid && rd_in_range) ? rd_data : 24'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer  <= 15'd0;
      bits_held   <= 4'd0;
      x_position  <= 8'd0;
      y_position  <= 8'd0;
      finished    <= 1'b0;
      pixel_count <= 3'd0;
      more        <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (cmd.table_write && wr_in_range) begin
        entry_valid[table_index[TABLE_AW-1:0]] <= 1'b1;
      end
      if (cmd.start_icon) begin
        bit_buffer <= 15'd0;
        bits_held  <= 4'd0;
        x_position <= 8'd0;
        y_position <= 8'd0;
        finished   <= 1'b0;
      end
      if (cmd.mark_finished) begin
        finished <= 1'b1;
      end
      if (cmd.load_byte) begin
        bit_buffer  <= {bit_buffer[6:0], body_byte};
        bits_held   <= bits_held + 4'd8;
        pixel_count <= 3'd0;
      end
      if (cmd.lookup) begin
        bits_held   <= shift;
        bit_buffer  <= buffer_after;
        pixel_count <= pixel_count + 3'd1;
        more        <= more_next;
        if (row_wrap) begin
          x_position <= 8'd0;
          y_position <= y_inc[7:0];
        end else begin
          x_position <= x_inc[7:0];
        end
        if (icon_end) begin
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_write && wr_in_range) begin
      colour_table[table_index[TABLE_AW-1:0]] <= {red_level, green_level, blue_level};
    end
    if (cmd.lookup) begin
      rd_data <= colour_table[point_ref[TABLE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_valid     <= entry_valid[point_ref[TABLE_AW-1:0]];
      rd_in_range  <= ref_in_range;
      column       <= x_position;
      line         <= y_position;
      icon_done    <= icon_end;
      last_of_byte <= !more_next;
    end
  end

  a_held_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |-> (bits_held <= 4'd7))
    else $error("bit buffer would overflow on a body byte");

  a_held_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |=> (bits_held >= 4'd8))
    else $error("body byte bits not counted");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> (!icon_done || (last_of_byte && finished)))
    else $error("icon end not flagged as the last pixel of its byte");

endmodule

`default_nettype wire

/* hw/rtl/clut_icon_pixel_unpacker.sv */
// Top level of the colour table icon pixel unpacker.
//
//  Channel    Direction  Handshake         Beat contents
//  in_item    sink       valid/ready       kind, table_index, red/green/blue level, body_byte
//  out_pixel  source     valid/ready       pixel_rgb, column, line, last_of_byte, icon_done
//  APB        slave      psel/penable      icon_width, icon_height, bits_per_point
//
// Table writes, start items and ignored bytes are handled in the idle state.
// A body byte is loaded in the idle state; each pixel it yields then takes a table read
// (S_LOOKUP), then the output beat (S_SHOW), before the next pixel or the next item.
// The colour table read port is shared by all pixels; one pixel is in flight at a time.
// Reset clears the per-entry valid bits at once; no clearing pass is run.
// While out_pixel is stalled the pixel beat holds and no new input beat is taken.
`default_nettype none

module clut_icon_pixel_unpacker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ciu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  ciu_in_if.sink                           in_item,
  ciu_out_if.source                        out_pixel
);
  import ciu_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ciu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ciu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_kind   (in_item.kind),
    .in_ready  (in_item.ready),
    .out_valid (out_pixel.valid),
    .out_ready (out_pixel.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ciu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .table_index  (in_item.table_index),
    .red_level    (in_item.red_level),
    .green_level  (in_item.green_level),
    .blue_level   (in_item.blue_level),
    .body_byte    (in_item.body_byte),
    .pixel_rgb    (out_pixel.pixel_rgb),
    .column       (out_pixel.column),
    .line         (out_pixel.line),
    .last_of_byte (out_pixel.last_of_byte),
    .icon_done    (out_pixel.icon_done)
  );

endmodule

`default_nettype wire

/* test/tb_clut_icon_pixel_unpacker.sv */
// Self-checking testbench for the colour table icon pixel unpacker, with its own decoder.
`default_nettype none

module tb_clut_icon_pixel_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import ciu_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [23:0] rgb;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        last;
    logic        done;
  } pixel_beat_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  ciu_in_if  in_ch();
  ciu_out_if out_ch();

  clut_icon_pixel_unpacker dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_item   (in_ch),
    .out_pixel (out_ch)
  );

  bit [23:0]   clut [TABLE_DEPTH];
  int          bitbuf = 0;
  int          held = 0;
  int          xpos = 0;
  int          ypos = 0;
  bit          icon_finished = 0;
  int          cfg_width = 0;
  int          cfg_height = 0;
  int          cfg_bpp = 8;

  pixel_beat_t pixels_due[$];
  int          errors = 0;
  int          items_sent = 0;
  int          pixels_checked = 0;
  int          icons_done = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          dst_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic int point_bits();
    if (cfg_bpp == 0) begin
      return 1;
    end
    if (cfg_bpp > 8) begin
      return 8;
    end
    return cfg_bpp;
  endfunction

  // Decodes one accepted input beat and queues the pixels it must produce.
  function automatic void unpack_item(input logic [1:0] kind, input logic [7:0] idx,
                                      input logic [23:0] rgb, input logic [7:0] body);
    pixel_beat_t burst [8];
    int          bpp;
    int          shift;
    int          entry;
    int          n;
    n = 0;
    case (kind)
      KIND_TABLE: begin
        if (idx < TABLE_DEPTH) begin
          clut[idx] = rgb;
        end
      end
      KIND_START: begin
        bitbuf = 0;
        held = 0;
        xpos = 0;
        ypos = 0;
        icon_finished = 1'b0;
      end
      KIND_BODY: begin
        if (!icon_finished) begin
          if (cfg_width == 0 || cfg_height == 0 || ypos >= cfg_height) begin
            icon_finished = 1'b1;
          end else begin
            bpp = point_bits();
            bitbuf = ((bitbuf << 8) | int'(body)) & 32'h7fff;
            held += 8;
            while (n < 8 && held >= bpp && !icon_finished) begin
              shift = held - bpp;
              entry = (bitbuf >> shift) & ((1 << bpp) - 1);
              held = shift;
              bitbuf &= (1 << held) - 1;
              burst[n].rgb = (entry < TABLE_DEPTH) ? clut[entry] : 24'd0;
              burst[n].col = xpos[7:0];
              burst[n].row = ypos[7:0];
              burst[n].last = 1'b0;
              burst[n].done = 1'b0;
              xpos++;
              if (xpos >= cfg_width) begin
                xpos = 0;
                ypos++;
                if (ypos >= cfg_height) begin
                  icon_finished = 1'b1;
                  burst[n].done = 1'b1;
                  icons_done++;
                end
              end
              n++;
            end
            if (n > 0) begin
              burst[n-1].last = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
              pixels_due.push_back(burst[i]);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pixel_rgb, out_ch.column, out_ch.line,
              out_ch.last_of_byte, out_ch.icon_done};
      pixels_checked++;
      if (pixels_due.size() == 0) begin
        note_error($sformatf("unexpected pixel rgb=%06h col=%0d row=%0d last=%0b done=%0b",
                             got.rgb, got.col, got.row, got.last, got.done));
      end else begin
        want = pixels_due.pop_front();
        if (got.rgb !== want.rgb || got.col !== want.col || got.row !== want.row ||
            got.last !== want.last || got.done !== want.done) begin
          note_error($sformatf({"pixel mismatch: want rgb=%06h col=%0d row=%0d last=%0b ",
                                "done=%0b, got rgb=%06h col=%0d row=%0d last=%0b done=%0b"},
                               want.rgb, want.col, want.row, want.last, want.done,
                               got.rgb, got.col, got.row, got.last, got.done));
        end
      end
    end
  end

  // Any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d pixels outstanding.", pixels_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [7:0] idx,
                      input logic [23:0] rgb, input logic [7:0] body);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.table_index <= idx;
    in_ch.red_level <= rgb[23:16];
    in_ch.green_level <= rgb[15:8];
    in_ch.blue_level <= rgb[7:0];
    in_ch.body_byte <= body;
    do @(posedge clk); while (!in_ch.ready);
    unpack_item(kind, idx, rgb, body);
    items_sent++;
  endtask

  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  cfg_width = value & 8'hff;
      REG_HEIGHT: cfg_height = value & 8'hff;
      REG_BPP:    cfg_bpp = value & 4'hf;
      default: ;
    endcase
  endtask

  task automatic test_empty_icon();
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hff);
    send(KIND_UNUSED, 8'($urandom), 24'($urandom), 8'($urandom));
    send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h00);
    drain_pixels();
    write_reg(REG_WIDTH, 5);
    send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h5a);
  endtask

  task automatic test_table_and_geometry();
    drain_pixels();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_BPP, 8);
    send(KIND_TABLE, 8'd0, 24'hff00ff, 8'($urandom));
    send(KIND_TABLE, 8'd255, 24'hffffff, 8'($urandom));
    send(KIND_TABLE, 8'd1, 24'h00ff00, 8'($urandom));
    send(KIND_TABLE, 8'd128, 24'h01807f, 8'($urandom));
    send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h00);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hff);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h01);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h80);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hfe);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h00);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hff);
  endtask

  task automatic test_point_widths();
    drain_pixels();
    write_reg(REG_WIDTH, 255);
    write_reg(REG_HEIGHT, 255);
    write_reg(REG_BPP, 1);
    send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'ha5);
    drain_pixels();
    write_reg(REG_BPP, 0);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h5a);
    drain_pixels();
    write_reg(REG_BPP, 15);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hff);
    drain_pixels();
    write_reg(REG_BPP, 3);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h96);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'h3c);
    drain_pixels();
    write_reg(REG_WIDTH, 2);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hc3);
    drain_pixels();
    write_reg(REG_HEIGHT, 1);
    send(KIND_BODY, 8'($urandom), 24'($urandom), 8'hff);
  endtask

  task automatic run_icons(input int src_pct, input int dst_pct, input int budget);
    int first;
    int w;
    int h;
    int nbytes;
    first = items_sent;
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
    while (items_sent - first < budget) begin
      drain_pixels();
      case ($urandom_range(9))
        0: w = 0;
        1: w = 255;
        default: w = int'($urandom_range(1, 6));
      endcase
      case ($urandom_range(9))
        0: h = 0;
        1: h = 255;
        default: h = int'($urandom_range(1, 4));
      endcase
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_BPP, int'($urandom_range(0, 15)));
      repeat ($urandom_range(0, 4)) begin
        send(KIND_TABLE,
             8'($urandom_range(1) ? $urandom_range(0, 15) : $urandom_range(0, 255)),
             24'($urandom), 8'($urandom));
      end
      if ($urandom_range(9) != 0) begin
        send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
      end
      nbytes = (w * h * point_bits() + 7) / 8 + int'($urandom_range(0, 2));
      if (nbytes > 24) begin
        nbytes = 24;
      end
      repeat (nbytes) begin
        case ($urandom_range(39))
          0: send(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
          1: begin
            drain_pixels();
            write_reg(REG_BPP, int'($urandom_range(0, 15)));
          end
          2, 3: send(KIND_UNUSED, 8'($urandom), 24'($urandom), 8'($urandom));
          4: send(KIND_TABLE, 8'($urandom), 24'($urandom), 8'($urandom));
          default: ;
        endcase
        send(KIND_BODY, 8'($urandom), 24'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TABLE;
    in_ch.table_index <= '0;
    in_ch.red_level <= '0;
    in_ch.green_level <= '0;
    in_ch.blue_level <= '0;
    in_ch.body_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_icon();
    test_table_and_geometry();
    test_point_widths();
    run_icons(0, 0, 35);
    run_icons(80, 0, 35);
    run_icons(0, 80, 35);
    run_icons(13, 13, 35);
    drain_pixels();

    if (pixels_due.size() != 0) begin
      note_error($sformatf("%0d pixels never arrived", pixels_due.size()));
    end
    $display("Sent %0d input beats and checked %0d pixel beats; %0d icons ran to completion.",
             items_sent, pixels_checked, icons_done);
    $display("Covered empty icons, point widths 0 to 15, mid-icon changes and four stall mixes.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/ciu_pkg.sv
hw/rtl/ciu_if.sv
hw/rtl/ciu_regs.sv
hw/rtl/ciu_ctrl.sv
hw/rtl/ciu_datapath.sv
hw/rtl/clut_icon_pixel_unpacker.sv
test/tb_clut_icon_pixel_unpacker.sv
